### sv/mtw_pkg.sv
package mtw_pkg;

    localparam int NUM_FRAMES   = 64;
    localparam int LEVELS       = 5;
    localparam int INDEX_BITS   = 9;

    localparam int ENTRIES      = 1 << INDEX_BITS;
    localparam int DEPTH        = NUM_FRAMES * ENTRIES;
    localparam int FRAME_BITS   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int ADDR_W       = FRAME_BITS + INDEX_BITS;
    localparam int LEVEL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int FU_W         = $clog2(NUM_FRAMES + 1);
    localparam int NF_W         = ((FU_W > 7) ? FU_W : 7) + 1;
    localparam bit FRAMES_POW2  = (NUM_FRAMES & (NUM_FRAMES - 1)) == 0;

    localparam int ENTRY_W      = 64;
    localparam int OFFSET_SHIFT = 12;
    localparam int PPN_W        = 52;
    localparam int VPN_W        = 45;
    localparam int REQ_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int ROOT_W       = 6;
    localparam int FREE_W       = 7;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 7;

    // frame-number reduction for a non power-of-two frame count
    localparam int RED_BITS     = 8;
    localparam int RED_STEPS    = (PPN_W + RED_BITS - 1) / RED_BITS;
    localparam int RAW_W        = RED_STEPS * RED_BITS;
    localparam int RED_CNT_W    = $clog2(RED_STEPS);

    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MAP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_UNMAP = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOMAP   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOFRAME = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'd1;

endpackage

### sv/mtw_req_if.sv
interface mtw_req_if;
    logic                            valid;
    logic                            ready;
    logic [mtw_pkg::REQ_W-1:0]       req_type;
    logic [mtw_pkg::VPN_W-1:0]       vpn;
    logic [mtw_pkg::PPN_W-1:0]       new_ppn;

    modport source (output valid, req_type, vpn, new_ppn, input ready);
    modport sink   (input valid, req_type, vpn, new_ppn, output ready);
endinterface

### sv/mtw_rsp_if.sv
interface mtw_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [mtw_pkg::STATUS_W-1:0]    status;
    logic [mtw_pkg::PPN_W-1:0]       ppn_out;

    modport source (output valid, status, ppn_out, input ready);
    modport sink   (input valid, status, ppn_out, output ready);
endinterface

### sv/mtw_ram.sv
module mtw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/multilevel_page_table_walker.sv
// Radix page table walker over an on-chip frame memory.
// req (sink): one request per transfer: req_type (query, map, unmap), vpn, new_ppn.
// rsp (source): one result per request, in request order: status and ppn_out.
// cfg_we/cfg_index/cfg_data: write root_frame (index 0) or first_free_frame
// (index 1); write only while no request is in flight.
// Walk: each of the up to five table levels visited runs a read issue state,
// then an evaluate state (S_ISSUE, S_EVAL); the result then passes through
// S_FINISH into the output register. req.ready stays low until then.
// The walk is bound by the registered frame memory read at each level,
// which the next level's address depends on. With a frame count that is
// not a power of two, each level first runs RED_STEPS frame reduction steps.
// Reset: the frame memory is swept to zero one entry a cycle (all DEPTH
// entries, 32768 at the default size); req.ready stays low until the sweep is done.
// Stall: a finished result waits in the output register; a new request is
// still taken, and its own result holds back until the register frees up.
module multilevel_page_table_walker (
    input  logic                               clk,
    input  logic                               rst_n,
    mtw_req_if.sink                            req,
    mtw_rsp_if.source                          rsp,
    input  logic                               cfg_we,
    input  logic [mtw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mtw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_REDUCE = 6'b000100,
        S_ISSUE  = 6'b001000,
        S_EVAL   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t                              state_reg, state_next;

    logic [mtw_pkg::ROOT_W-1:0]          root_reg;
    logic [mtw_pkg::FREE_W-1:0]          free_reg;
    logic [mtw_pkg::FU_W-1:0]            fu_reg, fu_next;
    logic [mtw_pkg::ADDR_W-1:0]          clr_addr_reg, clr_addr_next;

    logic [mtw_pkg::REQ_W-1:0]           type_reg, type_next;
    logic [mtw_pkg::VPN_W-1:0]           vpn_reg, vpn_next;
    logic [mtw_pkg::PPN_W-1:0]           ppn_reg, ppn_next;
    logic [mtw_pkg::LEVEL_W-1:0]         level_reg, level_next;
    logic [mtw_pkg::RAW_W-1:0]           raw_reg, raw_next;
    logic [mtw_pkg::FRAME_BITS-1:0]      red_val_reg, red_val_next;
    logic [mtw_pkg::RED_CNT_W-1:0]       red_cnt_reg, red_cnt_next;
    logic [mtw_pkg::STATUS_W-1:0]        status_reg, status_next;
    logic [mtw_pkg::PPN_W-1:0]           found_reg, found_next;

    logic                                out_valid_reg, out_valid_next;
    logic [mtw_pkg::STATUS_W-1:0]        out_status_reg, out_status_next;
    logic [mtw_pkg::PPN_W-1:0]           out_ppn_reg, out_ppn_next;

    logic                                ram_we;
    logic [mtw_pkg::ADDR_W-1:0]          ram_waddr;
    logic [mtw_pkg::ENTRY_W-1:0]         ram_wdata;
    logic [mtw_pkg::ENTRY_W-1:0]         ram_rdata;

    logic [mtw_pkg::FRAME_BITS-1:0]      frame_cur;
    logic [mtw_pkg::INDEX_BITS-1:0]      walk_idx;
    logic [mtw_pkg::ADDR_W-1:0]          walk_addr;
    logic [mtw_pkg::NF_W-1:0]            new_frame;
    logic                                entry_valid;
    logic                                in_xfer;
    logic                                out_free;
    logic [mtw_pkg::FRAME_BITS-1:0]      red_step_val;

    assign in_xfer     = req.valid && req.ready;
    assign req.ready   = (state_reg == S_IDLE);
    assign out_free    = !out_valid_reg || rsp.ready;
    assign entry_valid = ram_rdata[0];

    assign frame_cur = mtw_pkg::FRAMES_POW2 ? raw_reg[mtw_pkg::FRAME_BITS-1:0] : red_val_reg;
    assign walk_idx  = vpn_reg[level_reg * mtw_pkg::INDEX_BITS +: mtw_pkg::INDEX_BITS];
    assign walk_addr = {frame_cur, walk_idx};
    assign new_frame = mtw_pkg::NF_W'(free_reg) + mtw_pkg::NF_W'(fu_reg);

    // eight restoring mod steps on the top byte of the raw frame number
    always_comb
    begin
        logic [mtw_pkg::FRAME_BITS:0] t;
        logic [mtw_pkg::FRAME_BITS-1:0] r;
        r = red_val_reg;
        for (int k = 0; k < mtw_pkg::RED_BITS; k++)
        begin
            t = {r, raw_reg[mtw_pkg::RAW_W-1-k]};
            if (t >= (mtw_pkg::FRAME_BITS+1)'(mtw_pkg::NUM_FRAMES))
            begin
                t = t - (mtw_pkg::FRAME_BITS+1)'(mtw_pkg::NUM_FRAMES);
            end
            r = t[mtw_pkg::FRAME_BITS-1:0];
        end
        red_step_val = r;
    end

    mtw_ram #(
        .WIDTH (mtw_pkg::ENTRY_W),
        .DEPTH (mtw_pkg::DEPTH)
    ) u_frames (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (walk_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        logic go_down;
        logic [mtw_pkg::RAW_W-1:0] down_raw;

        state_next      = state_reg;
        fu_next         = fu_reg;
        clr_addr_next   = clr_addr_reg;
        type_next       = type_reg;
        vpn_next        = vpn_reg;
        ppn_next        = ppn_reg;
        level_next      = level_reg;
        raw_next        = raw_reg;
        red_val_next    = red_val_reg;
        red_cnt_next    = red_cnt_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_ppn_next    = out_ppn_reg;
        ram_we          = 1'b0;
        ram_waddr       = walk_addr;
        ram_wdata       = '0;
        go_down         = 1'b0;
        down_raw        = '0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + mtw_pkg::ADDR_W'(1);
                if (clr_addr_reg == mtw_pkg::ADDR_W'(mtw_pkg::DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    type_next    = req.req_type;
                    vpn_next     = req.vpn;
                    ppn_next     = req.new_ppn;
                    level_next   = mtw_pkg::LEVEL_W'(mtw_pkg::LEVELS - 1);
                    raw_next     = mtw_pkg::RAW_W'(root_reg);
                    red_val_next = '0;
                    red_cnt_next = '0;
                    status_next  = mtw_pkg::STAT_OK;
                    found_next   = '0;
                    if (req.req_type == mtw_pkg::REQ_NONE)
                    begin
                        status_next = mtw_pkg::STAT_NOMAP;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        state_next = mtw_pkg::FRAMES_POW2 ? S_ISSUE : S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                red_val_next = red_step_val;
                raw_next     = raw_reg << mtw_pkg::RED_BITS;
                red_cnt_next = red_cnt_reg + mtw_pkg::RED_CNT_W'(1);
                if (red_cnt_reg == mtw_pkg::RED_CNT_W'(mtw_pkg::RED_STEPS - 1))
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                // read of walk_addr is in flight; data arrives in S_EVAL
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (level_reg != '0)
                begin
                    if (entry_valid)
                    begin
                        go_down  = 1'b1;
                        down_raw = mtw_pkg::RAW_W'(ram_rdata[mtw_pkg::ENTRY_W-1:mtw_pkg::OFFSET_SHIFT]);
                    end
                    else if (type_reg != mtw_pkg::REQ_MAP)
                    begin
                        status_next = mtw_pkg::STAT_NOMAP;
                        state_next  = S_FINISH;
                    end
                    else if (new_frame >= mtw_pkg::NF_W'(mtw_pkg::NUM_FRAMES))
                    begin
                        status_next = mtw_pkg::STAT_NOFRAME;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = (mtw_pkg::ENTRY_W'(new_frame) << mtw_pkg::OFFSET_SHIFT)
                                    | mtw_pkg::ENTRY_W'(1);
                        fu_next   = fu_reg + mtw_pkg::FU_W'(1);
                        go_down   = 1'b1;
                        down_raw  = mtw_pkg::RAW_W'(new_frame);
                    end
                end
                else
                begin
                    state_next = S_FINISH;
                    case (type_reg)
                        mtw_pkg::REQ_QUERY:
                        begin
                            if (entry_valid)
                            begin
                                found_next = ram_rdata[mtw_pkg::ENTRY_W-1:mtw_pkg::OFFSET_SHIFT];
                            end
                            else
                            begin
                                status_next = mtw_pkg::STAT_NOMAP;
                            end
                        end
                        mtw_pkg::REQ_MAP:
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {ppn_reg, {(mtw_pkg::OFFSET_SHIFT-1){1'b0}}, 1'b1};
                        end
                        default:
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = '0;
                            if (!entry_valid)
                            begin
                                status_next = mtw_pkg::STAT_NOMAP;
                            end
                        end
                    endcase
                end
                if (go_down)
                begin
                    level_next   = level_reg - mtw_pkg::LEVEL_W'(1);
                    raw_next     = down_raw;
                    red_val_next = '0;
                    red_cnt_next = '0;
                    state_next   = mtw_pkg::FRAMES_POW2 ? S_ISSUE : S_REDUCE;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_ppn_next    = found_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            fu_reg        <= '0;
            out_valid_reg <= 1'b0;
            root_reg      <= '0;
            free_reg      <= mtw_pkg::FREE_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            fu_reg        <= fu_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == mtw_pkg::CFG_ROOT_FRAME)
            begin
                root_reg <= cfg_data[mtw_pkg::ROOT_W-1:0];
            end
            if (cfg_we && cfg_index == mtw_pkg::CFG_FIRST_FREE)
            begin
                free_reg <= cfg_data[mtw_pkg::FREE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg       <= type_next;
        vpn_reg        <= vpn_next;
        ppn_reg        <= ppn_next;
        level_reg      <= level_next;
        raw_reg        <= raw_next;
        red_val_reg    <= red_val_next;
        red_cnt_reg    <= red_cnt_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
        out_status_reg <= out_status_next;
        out_ppn_reg    <= out_ppn_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.ppn_out = out_ppn_reg;

`ifndef SYNTH
    a_fu_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fu_reg <= mtw_pkg::FU_W'(mtw_pkg::NUM_FRAMES))
        else $error("frame counter passed capacity");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_EVAL))
        else $error("frame memory written outside clear or evaluate");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg != S_IDLE)
        else $error("walker idle right after a request transfer");

    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && ram_we && level_reg != '0)
        |=> fu_reg == $past(fu_reg) + mtw_pkg::FU_W'(1))
        else $error("table allocation did not advance the frame counter");

    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_valid_reg && !rsp.ready) |=> state_reg == S_FINISH)
        else $error("result dropped while output register full");
`endif

endmodule
